FILE: rtl/epwr_pkg.sv
package epwr_pkg;

	// Operation codes on the request channel
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Captured timer count and distance widths
	localparam int COUNT_BITS = 16;
	localparam int DIST_BITS  = 16;

	// Distance = ticks * 340 / 20000 = ticks * 17 / 1000, saturated at all ones.
	// ticks * 17 / 1000 >= 65536 exactly when ticks >= SAT_TICKS.
	localparam int          TICK_CALC_BITS = 32;
	localparam logic [31:0] SAT_TICKS      = 32'd3855059;

	// Below SAT_TICKS the tick count fits in 22 bits. For such values
	// (ticks * RECIP_MULT) >> RECIP_SHIFT equals ticks * 17 / 1000 exactly,
	// since RECIP_MULT * 1000 - 17 * 2^32 = 968 and 2^22 * 968 < 2^32.
	localparam int          MUL_TICK_BITS = 22;
	localparam int          RECIP_BITS    = 27;
	localparam int          RECIP_SHIFT   = 32;
	localparam logic [26:0] RECIP_MULT    = 27'd73014445;
	localparam int          PROD_BITS     = MUL_TICK_BITS + RECIP_BITS;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [DIST_BITS-1:0]  dist_t;
	typedef logic [PROD_BITS-1:0]  prod_t;

	// Flags that travel with each result
	typedef struct packed {
		logic done;
		logic high;
		logic clear;
		logic falling;
	} flags_t;

endpackage

FILE: rtl/echo_pulse_width_ranger.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | operation, overflow_event, edge_event,
//          |                      | captured_count
// out      | out_valid / out_stall| distance_cm, measurement_done, pulse_high,
//          |                      | clear_counter, falling_edge_select
//
// One request per cycle while the output is not stalled. A request passes the input register,
// then flag update and distance multiply into the second stage, then the result register.
// The pulse flags and counts update as a request leaves the input register, so
// back-to-back requests see each other's effect. The distance is one 22x27 multiply.
// arst_n clears all flags, counts and the held distance. A stalled output
// holds its result and backs up the pipeline one stage at a time.
module echo_pulse_width_ranger
	import epwr_pkg::*;
#(
	parameter int OVERFLOW_BITS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic                  overflow_event,
	input  logic                  edge_event,
	input  logic [COUNT_BITS-1:0] captured_count,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DIST_BITS-1:0]  distance_cm,
	output logic                  measurement_done,
	output logic                  pulse_high,
	output logic                  clear_counter,
	output logic                  falling_edge_select
);

	localparam int TICK_BITS = OVERFLOW_BITS + COUNT_BITS;

	// Pipeline control
	logic out_ready;
	logic s2_ready;
	logic s1_ready;
	logic adv_s1;
	logic adv_s2;

	// Input stage
	logic   valid_s1;
	logic   op_s1;
	logic   ovf_ev_s1;
	logic   edge_ev_s1;
	count_t cap_s1;

	// Pulse state
	logic                     done_q;
	logic                     high_q;
	logic                     falling_q;
	logic [OVERFLOW_BITS-1:0] ovf_cnt_q;
	count_t                   held_q;
	dist_t                    last_dist_q;

	// Next state
	logic                     done_d;
	logic                     high_d;
	logic                     falling_d;
	logic                     clear_d;
	logic                     conv_d;
	logic [OVERFLOW_BITS-1:0] ovf_cnt_d;
	count_t                   held_d;

	// Conversion
	logic [TICK_BITS-1:0]      ticks;
	logic [TICK_CALC_BITS-1:0] ticks_ext;
	logic                      sat_d;
	prod_t                     prod_d;

	// Second stage
	logic   valid_s2;
	logic   conv_s2;
	logic   sat_s2;
	prod_t  prod_s2;
	flags_t flags_s2;
	dist_t  dist_new;

	// Result register
	logic   out_valid_q;
	dist_t  dist_q;
	flags_t flags_q;

	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign adv_s1    = valid_s1 && s2_ready;
	assign adv_s2    = valid_s2 && out_ready;
	assign in_stall  = !s1_ready;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			op_s1      <= operation;
			ovf_ev_s1  <= overflow_event;
			edge_ev_s1 <= edge_event;
			cap_s1     <= captured_count;
		end
	end

	// Apply the request to the pulse state: overflow first, edge second
	always_comb begin
		done_d    = done_q;
		high_d    = high_q;
		falling_d = falling_q;
		ovf_cnt_d = ovf_cnt_q;
		held_d    = held_q;
		clear_d   = 1'b0;
		conv_d    = 1'b0;
		unique case (op_s1)
			OP_READ: begin
				if (done_q) begin
					conv_d    = 1'b1;
					done_d    = 1'b0;
					high_d    = 1'b0;
					ovf_cnt_d = '0;
				end
			end
			OP_EVENT: begin
				if (!done_q) begin
					if (ovf_ev_s1 && high_q) begin
						if (ovf_cnt_q == '1) begin
							done_d = 1'b1;
							held_d = '1;
						end else begin
							ovf_cnt_d = ovf_cnt_q + 1'b1;
						end
					end
					if (edge_ev_s1) begin
						if (high_q) begin
							done_d    = 1'b1;
							held_d    = cap_s1;
							falling_d = 1'b0;
						end else begin
							ovf_cnt_d = '0;
							held_d    = '0;
							high_d    = 1'b1;
							falling_d = 1'b1;
							clear_d   = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Scale the held pulse by the reciprocal of the speed divisor
	always_comb begin
		ticks     = {ovf_cnt_q, held_q};
		ticks_ext = TICK_CALC_BITS'(ticks);
		sat_d     = ticks_ext >= SAT_TICKS;
		prod_d    = PROD_BITS'(ticks_ext[MUL_TICK_BITS-1:0]) * PROD_BITS'(RECIP_MULT);
	end

	// Advance the pulse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			high_q    <= 1'b0;
			falling_q <= 1'b0;
			ovf_cnt_q <= '0;
			held_q    <= '0;
		end else if (adv_s1) begin
			done_q    <= done_d;
			high_q    <= high_d;
			falling_q <= falling_d;
			ovf_cnt_q <= ovf_cnt_d;
			held_q    <= held_d;
		end
	end

	// Second stage: flags and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			conv_s2  <= 1'b0;
			flags_s2 <= '0;
		end else if (s2_ready) begin
			valid_s2 <= adv_s1;
			if (adv_s1) begin
				conv_s2  <= conv_d;
				flags_s2 <= '{done: done_d, high: high_d, clear: clear_d,
					falling: falling_d};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && conv_d) begin
			sat_s2  <= sat_d;
			prod_s2 <= prod_d;
		end
	end

	assign dist_new = sat_s2 ? '1 : prod_s2[RECIP_SHIFT +: DIST_BITS];

	// Result register and held distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_dist_q <= '0;
			dist_q      <= '0;
			flags_q     <= '0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
			if (adv_s2) begin
				flags_q <= flags_s2;
				if (conv_s2) begin
					last_dist_q <= dist_new;
					dist_q      <= dist_new;
				end else begin
					dist_q <= last_dist_q;
				end
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign distance_cm         = dist_q;
	assign measurement_done    = flags_q.done;
	assign pulse_high          = flags_q.high;
	assign clear_counter       = flags_q.clear;
	assign falling_edge_select = flags_q.falling;

endmodule
